// File: hw/rtl/json_string_unescaper_assert.svh
// Assertion macros for the JSON string unescaper.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef JSON_STRING_UNESCAPER_ASSERT_SVH
`define JSON_STRING_UNESCAPER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// expr must hold on every clock edge outside reset
`define JSU_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// cons must hold on any edge where ante holds
`define JSU_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define JSU_ASSERT_ALWAYS(label, clk, rst, expr)
`define JSU_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

// File: hw/rtl/jsu_pkg.sv
package jsu_pkg;

  // longest decoded length reported; the counter saturates here
  localparam logic [15:0] LEN_LIMIT = 16'hFFFF;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // special input characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_NO_OPEN = 3'd1,
    ERR_BAD_ESC = 3'd2,
    ERR_BAD_HEX = 3'd3,
    ERR_UNTERM  = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_BODY = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic [15:0] out_length;
    err_t        error_code;
    logic        last;
  } out_t;

  // one input beat worth of results, 1 to 3 of them
  typedef struct packed {
    logic [1:0]      count;
    kind_t           kind;
    logic [2:0][7:0] bytes;
    logic [15:0]     length;
    err_t            err;
  } cmd_t;

  // front -> queue
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } cmd_wr_t;

  // queue -> back
  typedef struct packed {
    logic empty;
    cmd_t cmd;
  } cmd_rd_t;

endpackage

// File: hw/rtl/jsu_front.sv
module jsu_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             full,
  input  jsu_pkg::in_t     data,
  output jsu_pkg::cmd_wr_t wr
);

  jsu_pkg::mode_t mode, mode_next;
  logic [1:0]     hex_count, hex_count_next;
  logic [15:0]    code_point, code_point_next;
  logic [15:0]    length_count, length_count_next;

  logic           take;
  logic [4:0]     hex;
  logic [15:0]    cp_new;
  logic [1:0]     nbytes;
  logic [17:0]    len_sum;

  // {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, c[3:0]};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, c[3:0] + 4'd9};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  assign take    = push && !full;
  assign hex     = hex_decode(data.in_byte);
  assign cp_new  = {code_point[11:0], hex[3:0]};
  assign len_sum = {2'b00, length_count} + {16'd0, nbytes};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= jsu_pkg::MODE_IDLE;
      hex_count    <= 2'd0;
      code_point   <= 16'd0;
      length_count <= 16'd0;
    end else if (take) begin
      mode         <= mode_next;
      hex_count    <= hex_count_next;
      code_point   <= code_point_next;
      length_count <= length_count_next;
    end
  end

  always_comb begin
    mode_next         = mode;
    hex_count_next    = hex_count;
    code_point_next   = code_point;
    length_count_next = length_count;
    nbytes            = 2'd0;
    wr                = '0;
    wr.cmd.kind       = jsu_pkg::KIND_BYTE;
    wr.cmd.err        = jsu_pkg::ERR_NONE;

    case (mode)
      jsu_pkg::MODE_IDLE: begin
        if (!data.end_of_input && data.in_byte == jsu_pkg::CH_QUOTE) begin
          mode_next = jsu_pkg::MODE_BODY;
        end else begin
          wr.push     = 1'b1;
          wr.cmd.kind = jsu_pkg::KIND_ERROR;
          wr.cmd.err  = jsu_pkg::ERR_NO_OPEN;
        end
      end
      jsu_pkg::MODE_BODY: begin
        if (data.end_of_input) begin
          wr.push     = 1'b1;
          wr.cmd.kind = jsu_pkg::KIND_ERROR;
          wr.cmd.err  = jsu_pkg::ERR_UNTERM;
        end else if (data.in_byte == jsu_pkg::CH_QUOTE) begin
          wr.push       = 1'b1;
          wr.cmd.kind   = jsu_pkg::KIND_CLOSE;
          wr.cmd.length = length_count;
        end else if (data.in_byte == jsu_pkg::CH_BSLASH) begin
          mode_next = jsu_pkg::MODE_ESC;
        end else begin
          nbytes          = 2'd1;
          wr.cmd.bytes[0] = data.in_byte;
        end
      end
      jsu_pkg::MODE_ESC: begin
        if (data.end_of_input) begin
          wr.push     = 1'b1;
          wr.cmd.kind = jsu_pkg::KIND_ERROR;
          wr.cmd.err  = jsu_pkg::ERR_UNTERM;
        end else begin
          mode_next = jsu_pkg::MODE_BODY;
          nbytes    = 2'd1;
          case (data.in_byte)
            8'h22:   wr.cmd.bytes[0] = 8'h22;
            8'h5C:   wr.cmd.bytes[0] = 8'h5C;
            8'h2F:   wr.cmd.bytes[0] = 8'h2F;
            8'h62:   wr.cmd.bytes[0] = 8'h08;
            8'h66:   wr.cmd.bytes[0] = 8'h0C;
            8'h6E:   wr.cmd.bytes[0] = 8'h0A;
            8'h72:   wr.cmd.bytes[0] = 8'h0D;
            8'h74:   wr.cmd.bytes[0] = 8'h09;
            8'h75: begin
              nbytes          = 2'd0;
              mode_next       = jsu_pkg::MODE_HEX;
              hex_count_next  = 2'd0;
              code_point_next = 16'd0;
            end
            default: begin
              nbytes      = 2'd0;
              wr.push     = 1'b1;
              wr.cmd.kind = jsu_pkg::KIND_ERROR;
              wr.cmd.err  = jsu_pkg::ERR_BAD_ESC;
            end
          endcase
        end
      end
      jsu_pkg::MODE_HEX: begin
        if (data.end_of_input) begin
          wr.push     = 1'b1;
          wr.cmd.kind = jsu_pkg::KIND_ERROR;
          wr.cmd.err  = jsu_pkg::ERR_UNTERM;
        end else if (!hex[4]) begin
          wr.push     = 1'b1;
          wr.cmd.kind = jsu_pkg::KIND_ERROR;
          wr.cmd.err  = jsu_pkg::ERR_BAD_HEX;
        end else if (hex_count != 2'd3) begin
          hex_count_next  = hex_count + 2'd1;
          code_point_next = cp_new;
        end else begin
          mode_next       = jsu_pkg::MODE_BODY;
          hex_count_next  = 2'd0;
          code_point_next = 16'd0;
          if (cp_new <= 16'h007F) begin
            nbytes          = 2'd1;
            wr.cmd.bytes[0] = cp_new[7:0];
          end else if (cp_new <= 16'h07FF) begin
            nbytes          = 2'd2;
            wr.cmd.bytes[0] = 8'hC0 | {3'b000, cp_new[10:6]};
            wr.cmd.bytes[1] = 8'h80 | {2'b00, cp_new[5:0]};
          end else begin
            nbytes          = 2'd3;
            wr.cmd.bytes[0] = 8'hE0 | {4'h0, cp_new[15:12]};
            wr.cmd.bytes[1] = 8'h80 | {2'b00, cp_new[11:6]};
            wr.cmd.bytes[2] = 8'h80 | {2'b00, cp_new[5:0]};
          end
        end
      end
      default: begin
        mode_next = jsu_pkg::MODE_IDLE;
      end
    endcase

    if (nbytes != 2'd0) begin
      wr.push = 1'b1;
      if (len_sum >= {2'b00, jsu_pkg::LEN_LIMIT}) begin
        length_count_next = jsu_pkg::LEN_LIMIT;
      end else begin
        length_count_next = len_sum[15:0];
      end
    end

    // close and every error leave the parser idle and cleared
    if (wr.push && wr.cmd.kind != jsu_pkg::KIND_BYTE) begin
      mode_next         = jsu_pkg::MODE_IDLE;
      hex_count_next    = 2'd0;
      code_point_next   = 16'd0;
      length_count_next = 16'd0;
    end
    if (mode == jsu_pkg::MODE_IDLE && mode_next == jsu_pkg::MODE_BODY) begin
      length_count_next = 16'd0;
    end

    wr.cmd.count = wr.cmd.kind == jsu_pkg::KIND_BYTE ? nbytes : 2'd1;
    wr.push      = wr.push && take;
  end

endmodule

// File: hw/rtl/jsu_fifo.sv
module jsu_fifo (
  input  logic             clk,
  input  logic             rst,
  input  jsu_pkg::cmd_wr_t wr,
  input  logic             rd_pop,
  output logic             full,
  output jsu_pkg::cmd_rd_t rd
);

  localparam int CW = jsu_pkg::FIFO_AW + 1;

  jsu_pkg::cmd_t               mem [jsu_pkg::FIFO_DEPTH];
  logic [jsu_pkg::FIFO_AW-1:0] wptr;
  logic [jsu_pkg::FIFO_AW-1:0] rptr;
  logic [CW-1:0]               count;
  logic                        do_wr;
  logic                        do_rd;

  assign full     = count == CW'(jsu_pkg::FIFO_DEPTH);
  assign rd.empty = count == '0;
  assign rd.cmd   = mem[rptr];
  assign do_wr    = wr.push && !full;
  assign do_rd    = rd_pop && !rd.empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + CW'(do_wr) - CW'(do_rd);
    end
  end

endmodule

// File: hw/rtl/jsu_back.sv
`include "json_string_unescaper_assert.svh"

module jsu_back (
  input  logic             clk,
  input  logic             rst,
  input  jsu_pkg::cmd_rd_t rd,
  output logic             rd_pop,
  input  logic             pop,
  output logic             empty,
  output jsu_pkg::out_t    result
);

  logic          out_valid;
  logic [1:0]    idx;
  logic          load;
  logic          final_beat;
  logic [7:0]    sel_byte;
  jsu_pkg::out_t item;

  assign empty      = !out_valid;
  assign load       = !out_valid || pop;
  assign final_beat = idx == rd.cmd.count - 2'd1;
  assign rd_pop     = load && !rd.empty && final_beat;

  always_comb begin
    case (idx)
      2'd0:    sel_byte = rd.cmd.bytes[0];
      2'd1:    sel_byte = rd.cmd.bytes[1];
      2'd2:    sel_byte = rd.cmd.bytes[2];
      default: sel_byte = 8'd0;
    endcase
    item            = '0;
    item.kind       = rd.cmd.kind;
    item.error_code = rd.cmd.err;
    item.last       = final_beat;
    if (rd.cmd.kind == jsu_pkg::KIND_BYTE) begin
      item.out_byte = sel_byte;
    end
    if (rd.cmd.kind == jsu_pkg::KIND_CLOSE) begin
      item.out_length = rd.cmd.length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= !rd.empty;
      if (!rd.empty) begin
        idx <= final_beat ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= item;
    end
  end

  `JSU_ASSERT_IMPLIES(a_single_non_byte, clk, rst, out_valid && result.kind != jsu_pkg::KIND_BYTE, result.last)
  `JSU_ASSERT_IMPLIES(a_err_only_on_error, clk, rst, out_valid && result.kind != jsu_pkg::KIND_ERROR, result.error_code == jsu_pkg::ERR_NONE)
  `JSU_ASSERT_IMPLIES(a_idx_in_cmd, clk, rst, !rd.empty, idx < rd.cmd.count)
  `JSU_ASSERT_ALWAYS(a_idx_zero_when_drained, clk, rst, !rd.empty || idx == 2'd0)

endmodule

// File: hw/rtl/json_string_unescaper.sv
// Channel   Dir  Handshake          Payload
// data      in   push / full        jsu_pkg::in_t  (in_byte, end_of_input)
// result    out  empty / pop        jsu_pkg::out_t (kind, out_byte, out_length,
//                                                   error_code, last)
//
// One input beat is taken every cycle while the command queue has room.
// Each beat yields 0 to 3 results; the output stage drains one result a
// cycle unless pop stalls, so a \u escape that encodes to 2 or 3 UTF-8
// bytes takes one output result per byte and the 4-entry queue absorbs it.
// A beat's first result goes through the queue and then the output register.
// rst is synchronous: parser idle, queue empty, output register empty.
// full rises only when the queue holds 4 beats waiting on a stalled pop.

module json_string_unescaper (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  jsu_pkg::in_t  data,
  output logic          empty,
  input  logic          pop,
  output jsu_pkg::out_t result
);

  jsu_pkg::cmd_wr_t wr;   // parsed beat into the queue
  jsu_pkg::cmd_rd_t rd;   // oldest parsed beat
  logic             rd_pop;

  // parser: quote / escape / hex state machine and the length counter
  jsu_front u_front (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .data (data),
    .wr   (wr)
  );

  // decouples the parser from output stalls
  jsu_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .rd_pop (rd_pop),
    .full   (full),
    .rd     (rd)
  );

  // splits each parsed beat into single results and marks the last one
  jsu_back u_back (
    .clk    (clk),
    .rst    (rst),
    .rd     (rd),
    .rd_pop (rd_pop),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

endmodule
